// ===== hdl/mrust_pkg.sv =====
// Shared types and constants for the recently-used symbol table.
`timescale 1ns / 1ps
`default_nettype none
package mrust_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned KeyW       = 16;
  localparam int unsigned CntW       = IdxW + 1;

  localparam logic [KeyW-1:0] LookupMask = KeyW'(4095);

  typedef enum logic [1:0] {
    CmdLookup = 2'd0,
    CmdDecode = 2'd1,
    CmdInsert = 2'd2
  } cmd_e;

endpackage
`default_nettype wire

// ===== hdl/mru_symbol_table_core.sv =====
// Top level of the recently-used symbol table with a rotating start pointer.
// A lookup scans the 32 positions; a hit past the front then spends a read and two writes on the swap.
// The next item is taken once its result is raised, or later while an unaccepted result holds the
// response state.
// Reset clears the start pointer and the per-entry valid bits, so the store reads as zero.
`timescale 1ns / 1ps
`default_nettype none
module mru_symbol_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] key_i,
  input  wire logic [4:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic [4:0]       found_position_o,
  output logic [15:0]      found_key_o
);

  localparam int unsigned IdxW = mrust_pkg::IdxW;
  localparam int unsigned KeyW = mrust_pkg::KeyW;
  localparam int unsigned CntW = mrust_pkg::CntW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StScan  = 4'd1;
  localparam logic [3:0] StIns   = 4'd2;
  localparam logic [3:0] StDRd   = 4'd3;
  localparam logic [3:0] StDWait = 4'd4;
  localparam logic [3:0] StProm  = 4'd5;
  localparam logic [3:0] StPWait = 4'd6;
  localparam logic [3:0] StWrA   = 4'd7;
  localparam logic [3:0] StWrB   = 4'd8;
  localparam logic [3:0] StResp  = 4'd9;

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] start_q, start_d;
  logic [mrust_pkg::TableDepth-1:0] vld_q, vld_d;
  logic            rd_vld_q, rd_vld_d;
  logic [1:0]      cmd_q, cmd_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] a_q, a_d;
  logic [IdxW-1:0] b_q, b_d;
  logic [KeyW-1:0] val_a_q, val_a_d;
  logic [KeyW-1:0] val_b_q, val_b_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            cmp_pend_q, cmp_pend_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            res_hit_q, res_hit_d;
  logic [IdxW-1:0] res_pos_q, res_pos_d;
  logic [KeyW-1:0] res_key_q, res_key_d;
  logic            out_valid_q, out_valid_d;
  logic            out_hit_q, out_hit_d;
  logic [IdxW-1:0] out_pos_q, out_pos_d;
  logic [KeyW-1:0] out_key_q, out_key_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [KeyW-1:0] ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [KeyW-1:0] ram_rdata;
  logic [KeyW-1:0] rd_data;
  logic [KeyW-1:0] want;
  logic            in_acc;

  mrust_ram #(
    .Width(KeyW),
    .Depth(mrust_pkg::TableDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_data    = rd_vld_q ? ram_rdata : '0;
  assign want       = key_q & mrust_pkg::LookupMask;

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    vld_d       = vld_q;
    rd_vld_d    = rd_vld_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pos_d       = pos_q;
    a_d         = a_q;
    b_d         = b_q;
    val_a_d     = val_a_q;
    val_b_d     = val_b_q;
    scan_d      = scan_q;
    cmp_pend_d  = cmp_pend_q;
    cmp_idx_d   = cmp_idx_q;
    res_hit_d   = res_hit_q;
    res_pos_d   = res_pos_q;
    res_key_d   = res_key_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_pos_d   = out_pos_q;
    out_key_d   = out_key_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_d      = command_i;
          key_d      = key_i;
          pos_d      = position_i;
          scan_d     = '0;
          cmp_pend_d = 1'b0;
          res_hit_d  = 1'b0;
          res_pos_d  = '0;
          res_key_d  = key_i;
          case (command_i)
            mrust_pkg::CmdLookup: state_d = StScan;
            mrust_pkg::CmdDecode: state_d = StDRd;
            mrust_pkg::CmdInsert: state_d = StIns;
            default: begin
              res_key_d = '0;
              state_d   = StResp;
            end
          endcase
        end
      end
      StScan: begin
        ram_re     = !scan_q[CntW-1];
        ram_raddr  = start_q + scan_q[IdxW-1:0];
        rd_vld_d   = vld_q[ram_raddr];
        cmp_pend_d = !scan_q[CntW-1];
        cmp_idx_d  = scan_q[IdxW-1:0];
        scan_d     = scan_q + CntW'(1);
        if (cmp_pend_q) begin
          if (rd_data == want) begin
            res_hit_d = 1'b1;
            res_pos_d = cmp_idx_q;
            pos_d     = cmp_idx_q;
            a_d       = start_q + cmp_idx_q;
            val_a_d   = want;
            state_d   = StProm;
          end else if (cmp_idx_q == IdxW'(mrust_pkg::TableDepth - 1)) begin
            state_d = StIns;
          end
        end
      end
      StIns: begin
        ram_we    = 1'b1;
        ram_waddr = start_q - IdxW'(1);
        ram_wdata = (cmd_q == mrust_pkg::CmdLookup) ? want : key_q;
        vld_d[ram_waddr] = 1'b1;
        start_d   = start_q - IdxW'(1);
        state_d   = StResp;
      end
      StDRd: begin
        ram_re    = 1'b1;
        ram_raddr = start_q + pos_q;
        rd_vld_d  = vld_q[ram_raddr];
        a_d       = start_q + pos_q;
        res_hit_d = 1'b1;
        res_pos_d = pos_q;
        state_d   = StDWait;
      end
      StDWait: begin
        val_a_d   = rd_data;
        res_key_d = rd_data;
        state_d   = StProm;
      end
      StProm: begin
        if (pos_q == '0) begin
          state_d = StResp;
        end else begin
          if (pos_q[IdxW-1]) begin
            b_d     = start_q - IdxW'(1);
            start_d = start_q - IdxW'(1);
          end else begin
            b_d = a_q - IdxW'(1);
          end
          ram_re    = 1'b1;
          ram_raddr = b_d;
          rd_vld_d  = vld_q[b_d];
          state_d   = StPWait;
        end
      end
      StPWait: begin
        val_b_d = rd_data;
        state_d = StWrA;
      end
      StWrA: begin
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = val_b_q;
        vld_d[a_q] = 1'b1;
        state_d   = StWrB;
      end
      StWrB: begin
        ram_we    = 1'b1;
        ram_waddr = b_q;
        ram_wdata = val_a_q;
        vld_d[b_q] = 1'b1;
        state_d   = StResp;
      end
      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_pos_d   = res_pos_q;
          out_key_d   = res_key_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      cmp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      vld_q       <= vld_d;
      rd_vld_q    <= rd_vld_d;
      cmp_pend_q  <= cmp_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    pos_q     <= pos_d;
    a_q       <= a_d;
    b_q       <= b_d;
    val_a_q   <= val_a_d;
    val_b_q   <= val_b_d;
    scan_q    <= scan_d;
    cmp_idx_q <= cmp_idx_d;
    res_hit_q <= res_hit_d;
    res_pos_q <= res_pos_d;
    res_key_q <= res_key_d;
    out_hit_q <= out_hit_d;
    out_pos_q <= out_pos_d;
    out_key_q <= out_key_d;
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign found_position_o = out_pos_q;
  assign found_key_o      = out_key_q;

  // A completed scan without a match must leave the scan state.
  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && cmp_pend_q && cmp_idx_q == IdxW'(mrust_pkg::TableDepth - 1))
    |=> (state_q != StScan))
    else $error("scan did not terminate after the last position");

  // A new result only appears after the response state.
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == StResp))
    else $error("result raised outside the response state");

  // An accepted item always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != StIdle))
    else $error("accepted item did not start");

  // The second swap write is always followed by the response.
  a_swap_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrB) |=> (state_q == StResp))
    else $error("swap did not complete into the response state");

  // Only the insert and the far promotion move the start pointer.
  a_start_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q != $past(start_q)) |-> ($past(state_q) == StIns || $past(state_q) == StProm))
    else $error("start pointer moved unexpectedly");

endmodule
`default_nettype wire

// ===== hdl/mrust_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrust_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_mru_symbol_table_core.sv =====
// Self-checking testbench for the recently-used symbol table core.
`timescale 1ns / 1ps
module tb_mru_symbol_table_core;

  localparam int unsigned TableDepth = mrust_pkg::TableDepth;
  localparam int unsigned IdxW = mrust_pkg::IdxW;
  localparam int unsigned KeyW = mrust_pkg::KeyW;
  localparam logic [KeyW-1:0] LookupMask = mrust_pkg::LookupMask;
  localparam logic [1:0] CmdLookup = mrust_pkg::CmdLookup;
  localparam logic [1:0] CmdDecode = mrust_pkg::CmdDecode;
  localparam logic [1:0] CmdInsert = mrust_pkg::CmdInsert;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int DirectedRows = 23;
  localparam int RandomPerPhase = 363;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] pos;
    logic [KeyW-1:0] key;
  } table_reply_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] pos;
    logic            fixed;
    table_reply_t    reply;
  } probe_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [1:0]      command_i;
  logic [15:0]     key_i;
  logic [4:0]      position_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic            hit_o;
  logic [4:0]      found_position_o;
  logic [15:0]     found_key_o;

  logic            row_fixed;
  table_reply_t    row_reply;

  logic [KeyW-1:0] shadow_keys [TableDepth];
  logic [IdxW-1:0] shadow_front;
  table_reply_t    awaited_replies [$];

  int source_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int lookup_hits = 0;
  int lookup_misses = 0;
  int decodes = 0;
  int inserts = 0;
  int unused_cmds = 0;
  int deep_hits = 0;

  // Extremes, the empty table, duplicate keys, the unused command and every promotion path.
  probe_row_t directed_probes [DirectedRows] = '{
    '{CmdLookup, 16'h0000, 5'd0,  1'b1, '{1'b1, 5'd0,  16'h0000}},
    '{CmdDecode, 16'h0000, 5'd31, 1'b1, '{1'b1, 5'd31, 16'h0000}},
    '{CmdUnused, 16'hFFFF, 5'd31, 1'b1, '{1'b0, 5'd0,  16'h0000}},
    '{CmdInsert, 16'hFFFF, 5'd0,  1'b1, '{1'b0, 5'd0,  16'hFFFF}},
    '{CmdLookup, 16'hFFFF, 5'd0,  1'b0, '0},
    '{CmdLookup, 16'hF000, 5'd31, 1'b0, '0},
    '{CmdInsert, 16'h0005, 5'd0,  1'b0, '0},
    '{CmdInsert, 16'h0005, 5'd0,  1'b0, '0},
    '{CmdLookup, 16'hA005, 5'd0,  1'b0, '0},
    '{CmdInsert, 16'h8000, 5'd0,  1'b0, '0},
    '{CmdInsert, 16'h7FFF, 5'd0,  1'b0, '0},
    '{CmdInsert, 16'h5555, 5'd21, 1'b0, '0},
    '{CmdInsert, 16'hAAAA, 5'd10, 1'b0, '0},
    '{CmdLookup, 16'h0AAA, 5'd0,  1'b0, '0},
    '{CmdLookup, 16'h0FFF, 5'd0,  1'b0, '0},
    '{CmdDecode, 16'h1234, 5'd1,  1'b0, '0},
    '{CmdDecode, 16'h0000, 5'd15, 1'b0, '0},
    '{CmdDecode, 16'hFFFF, 5'd16, 1'b0, '0},
    '{CmdDecode, 16'h0000, 5'd0,  1'b0, '0},
    '{CmdLookup, 16'h0000, 5'd0,  1'b0, '0},
    '{CmdUnused, 16'h0000, 5'd0,  1'b1, '{1'b0, 5'd0,  16'h0000}},
    '{CmdInsert, 16'h0000, 5'd0,  1'b1, '{1'b0, 5'd0,  16'h0000}},
    '{CmdDecode, 16'h0000, 5'd31, 1'b0, '0}
  };

  mru_symbol_table_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .key_i            (key_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .found_position_o (found_position_o),
    .found_key_o      (found_key_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_front_key(input logic [KeyW-1:0] key);
    shadow_front = shadow_front - IdxW'(1);
    shadow_keys[shadow_front] = key;
  endfunction

  function automatic void promote_entry(input logic [IdxW-1:0] pos);
    logic [IdxW-1:0] here;
    logic [IdxW-1:0] there;
    logic [KeyW-1:0] held;
    here = shadow_front + pos;
    if (pos >= IdxW'(TableDepth / 2)) begin
      shadow_front = shadow_front - IdxW'(1);
      there = shadow_front;
    end else if (pos != '0) begin
      there = here - IdxW'(1);
    end else begin
      return;
    end
    held = shadow_keys[here];
    shadow_keys[here] = shadow_keys[there];
    shadow_keys[there] = held;
  endfunction

  function automatic table_reply_t compute_table_reply(input logic [1:0] cmd,
                                                       input logic [KeyW-1:0] key,
                                                       input logic [IdxW-1:0] pos);
    table_reply_t    reply;
    logic [KeyW-1:0] want;
    logic [IdxW-1:0] idx;
    int              hit_at;
    reply = '0;
    want = key & LookupMask;
    hit_at = -1;
    case (cmd)
      CmdLookup: begin
        for (int i = 0; i < TableDepth; i++) begin
          idx = shadow_front + IdxW'(i);
          if (hit_at < 0 && shadow_keys[idx] == want) hit_at = i;
        end
        if (hit_at >= 0) begin
          reply.hit = 1'b1;
          reply.pos = IdxW'(hit_at);
          promote_entry(reply.pos);
          lookup_hits++;
          if (hit_at >= TableDepth / 2) deep_hits++;
        end else begin
          push_front_key(want);
          lookup_misses++;
        end
        reply.key = key;
      end
      CmdDecode: begin
        idx = shadow_front + pos;
        reply.hit = 1'b1;
        reply.pos = pos;
        reply.key = shadow_keys[idx];
        promote_entry(pos);
        decodes++;
      end
      CmdInsert: begin
        push_front_key(key);
        reply.key = key;
        inserts++;
      end
      default: begin
        unused_cmds++;
      end
    endcase
    return reply;
  endfunction

  task automatic offer_item(input logic [1:0] cmd, input logic [KeyW-1:0] key,
                            input logic [IdxW-1:0] pos, input logic fixed,
                            input table_reply_t fixed_reply);
    while ($urandom_range(0, 99) < source_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= key;
    position_i <= pos;
    row_fixed  <= fixed;
    row_reply  <= fixed_reply;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin : scoreboard
    table_reply_t predicted;
    table_reply_t awaited;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = compute_table_reply(command_i, key_i, position_i);
        awaited_replies.push_back(row_fixed ? row_reply : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          $error("result item arrived with nothing expected");
          mismatch_count++;
        end else begin
          awaited = awaited_replies.pop_front();
          if (hit_o !== awaited.hit) begin
            $error("hit: expected %0d, got %0d", awaited.hit, hit_o);
            mismatch_count++;
          end
          if (found_position_o !== awaited.pos) begin
            $error("found_position: expected %0d, got %0d", awaited.pos, found_position_o);
            mismatch_count++;
          end
          if (found_key_o !== awaited.key) begin
            $error("found_key: expected 0x%04h, got 0x%04h", awaited.key, found_key_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0]      cmd;
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] pos;
    int              sel;
    logic [IdxW-1:0] pick;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = '0;
    key_i       = '0;
    position_i  = '0;
    row_fixed   = 1'b0;
    row_reply   = '0;
    shadow_front = '0;
    for (int i = 0; i < TableDepth; i++) shadow_keys[IdxW'(i)] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < DirectedRows; r++) begin
      offer_item(directed_probes[r].cmd, directed_probes[r].key, directed_probes[r].pos,
                 directed_probes[r].fixed, directed_probes[r].reply);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin source_idle_pct = 71; sink_stall_pct = 0;  end
        2: begin source_idle_pct = 0;  sink_stall_pct = 71; end
        default: begin source_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        sel = $urandom_range(0, 99);
        key = KeyW'($urandom);
        pos = IdxW'($urandom);
        if (sel < 50) begin
          cmd = CmdLookup;
          if ($urandom_range(0, 99) < 55) begin
            pick = IdxW'($urandom_range(0, TableDepth - 1));
            key[11:0] = shadow_keys[pick][11:0];
          end
        end else if (sel < 70) begin
          cmd = CmdDecode;
        end else if (sel < 95) begin
          cmd = CmdInsert;
        end else begin
          cmd = CmdUnused;
        end
        offer_item(cmd, key, pos, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d lookup hits (%0d in the back half), %0d lookup misses,",
             lookup_hits, deep_hits, lookup_misses);
    $display("%0d decodes, %0d inserts and %0d unused commands under four flow-control mixes.",
             decodes, inserts, unused_cmds);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
